>>> rtl/core/ecr_pkg.sv
// Shared types and constants of the expiring credit ring.
`default_nettype none

package ecr_pkg;

	// Fixed field widths.
	localparam int AMT_W   = 32;
	localparam int TOTAL_W = 35;
	localparam int USE_W   = 4;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	// Operation codes.
	localparam logic [1:0] OP_ADD     = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_CONSUME = 2'd2;

	// Register index, taken from paddr[2].
	localparam logic REG_SLOTS_IN_USE = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CONS,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

>>> rtl/core/expiring_credit_ring.sv
// Top level of the expiring credit ring: sequencer, slot memory and result register.
`default_nettype none

// The expiring credit ring keeps credit in a ring of slots_in_use slots, so credit
// lives for that many ticks. A request word carries an op and an amount: an add
// puts the amount into the current slot and saturates the slot at all ones; a tick
// steps the current index back one place and discards that slot, the oldest; a
// consume draws the demand from the slot that expires next, oldest first, and
// reports in unmet_demand what it could not cover. Every response word also gives
// total_left, the credit held after the operation. One request is worked on at a
// time and req_ready is high only while the block is idle. The slots sit in a
// memory with one write port and one registered read port, and the slot arithmetic
// works on the slot word read from that port. An add or a tick passes through an
// execute step and then the finish step, which loads the response word; a consume
// visits one slot per step until the demand is met, every active slot has been
// visited or the store runs dry, and then finishes. A consume with nothing to draw
// or an unknown op goes straight to the finish step. The block is ready again in
// the cycle after the response word is loaded. A response word waits in its own
// register, and the next request is taken while it waits; that request then holds
// in its last step until the waiting word is taken. Reset and any write to
// slots_in_use empty the store at once through a valid bit per slot, so there is
// no clearing pass. A write of zero to slots_in_use is taken as one, and a value
// above SLOTS as SLOTS. Configuration must be written only while the block is idle;
// the block itself does not enforce this.
module expiring_credit_ring
	import ecr_pkg::*;
#(
	parameter int SLOTS = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// Request channel.
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire logic [1:0]          op,
	input  wire logic [AMT_W-1:0]    amount,
	// Response channel.
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output logic [AMT_W-1:0]         unmet_demand,
	output logic [TOTAL_W-1:0]       total_left,
	// Configuration port.
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [ADDR_W-1:0]   paddr,
	input  wire logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready
);

	// Index width, and a compare width that holds both an index and slots_in_use.
	localparam int IW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CMP_W   = (IW > USE_W) ? IW : USE_W;
	// Only the active slots ever hold credit, and at most fifteen can be active.
	localparam int ACT_MAX = (SLOTS < 15) ? SLOTS : 15;
	localparam int TOT_W   = AMT_W + $clog2(ACT_MAX);
	localparam int USE_RST = (SLOTS < 8) ? SLOTS : 8;

	// Previous index around the active ring.
	function automatic logic [IW-1:0] step_back(input logic [IW-1:0] idx,
			input logic [USE_W-1:0] n_use);
		logic [IW-1:0] res;
		if (idx == '0 || CMP_W'(idx) >= CMP_W'(n_use)) begin
			res = IW'(n_use - USE_W'(1));
		end else begin
			res = idx - IW'(1);
		end
		return res;
	endfunction

	state_t              state_q, state_nxt;
	logic [USE_W-1:0]    use_q;
	logic [IW-1:0]       cur_q;
	logic [TOT_W-1:0]    total_q;
	logic [1:0]          op_q;
	logic [AMT_W-1:0]    demand_q;
	logic [IW-1:0]       idx_q;
	logic [USE_W-1:0]    cnt_q;
	logic [SLOTS-1:0]    valid_q;
	logic [AMT_W-1:0]    rd_data_q;
	logic                rd_vld_q;
	logic                rsp_valid_q;
	logic [AMT_W-1:0]    rsp_unmet_q;
	logic [TOTAL_W-1:0]  rsp_total_q;

	logic [AMT_W-1:0]    mem [SLOTS];

	logic                req_fire;
	logic                cfg_wr;
	logic                rsp_free;
	logic [IW-1:0]       cur_eff;
	logic [IW-1:0]       start_idx;
	logic [IW-1:0]       rd_addr;
	logic [AMT_W-1:0]    slot_val;
	logic                mem_we;
	logic [AMT_W-1:0]    mem_wdata;
	logic [AMT_W-1:0]    demand_nxt;
	logic [TOT_W-1:0]    total_nxt;
	logic                cons_met;
	logic                cons_last;
	logic                cons_work;
	logic [USE_W-1:0]    use_wr;

	// The slot arithmetic: room left in the slot, the amount that fits and the total less the slot.
	logic [AMT_W-1:0]    room;
	logic [AMT_W-1:0]    add_amt;
	logic [TOT_W-1:0]    total_less_slot;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_SLOTS_IN_USE);
	assign req_fire = req_valid && req_ready;
	assign rsp_free = !rsp_valid_q || rsp_ready;

	assign rsp_valid    = rsp_valid_q;
	assign unmet_demand = rsp_unmet_q;
	assign total_left   = rsp_total_q;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_SLOTS_IN_USE) begin
			prdata = DATA_W'(use_q);
		end
	end

	// A write of zero counts as one; anything above SLOTS is clamped.
	always_comb begin
		use_wr = pwdata[USE_W-1:0];
		if (use_wr == '0) begin
			use_wr = USE_W'(1);
		end else if (32'(use_wr) > SLOTS) begin
			use_wr = USE_W'(SLOTS);
		end
	end

	assign cur_eff   = (CMP_W'(cur_q) < CMP_W'(use_q)) ? cur_q : '0;
	assign start_idx = (op == OP_ADD) ? cur_eff : step_back(cur_eff, use_q);
	assign cons_work = (total_q != '0) && (amount != '0);

	// A slot whose valid bit is clear reads as empty.
	assign slot_val        = rd_vld_q ? rd_data_q : '0;
	assign room            = ~slot_val;
	assign add_amt         = (demand_q < room) ? demand_q : room;
	assign cons_met        = (slot_val >= demand_q);
	assign total_less_slot = total_q - TOT_W'(slot_val);
	assign cons_last       = ((cnt_q + USE_W'(1)) >= use_q) || (total_less_slot == '0);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (op == OP_ADD || op == OP_TICK) begin
						state_nxt = ST_EXEC;
					end else if (op == OP_CONSUME && cons_work) begin
						state_nxt = ST_CONS;
					end else begin
						state_nxt = ST_FIN;
					end
				end
			end
			ST_EXEC: begin
				state_nxt = ST_FIN;
			end
			ST_CONS: begin
				if (cons_met || cons_last) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				if (rsp_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer: memory port and the datapath results.
	always_comb begin
		req_ready  = 1'b0;
		rd_addr    = idx_q;
		mem_we     = 1'b0;
		mem_wdata  = '0;
		demand_nxt = demand_q;
		total_nxt  = total_q;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				rd_addr   = start_idx;
			end
			ST_EXEC: begin
				mem_we     = 1'b1;
				demand_nxt = '0;
				if (op_q == OP_ADD) begin
					mem_wdata = slot_val + add_amt;
					total_nxt = total_q + TOT_W'(add_amt);
				end else begin
					mem_wdata = '0;
					total_nxt = total_less_slot;
				end
			end
			ST_CONS: begin
				mem_we  = 1'b1;
				rd_addr = step_back(idx_q, use_q);
				if (cons_met) begin
					mem_wdata  = slot_val - demand_q;
					total_nxt  = total_q - TOT_W'(demand_q);
					demand_nxt = '0;
				end else begin
					mem_wdata  = '0;
					total_nxt  = total_less_slot;
					demand_nxt = demand_q - slot_val;
				end
			end
			ST_FIN: begin
				rd_addr = idx_q;
			end
			default: begin
				rd_addr = idx_q;
			end
		endcase
	end

	// Slot memory.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx_q] <= mem_wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			use_q       <= USE_W'(USE_RST);
			cur_q       <= '0;
			total_q     <= '0;
			valid_q     <= '0;
			rd_vld_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q  <= state_nxt;
			rd_vld_q <= valid_q[rd_addr];
			if (state_q == ST_CONS) begin
				cnt_q <= cnt_q + USE_W'(1);
			end else if (req_fire) begin
				cnt_q <= '0;
			end
			if (state_q == ST_FIN && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			// A configuration write rebuilds the store from empty.
			if (cfg_wr) begin
				use_q   <= use_wr;
				cur_q   <= '0;
				total_q <= '0;
				valid_q <= '0;
			end else begin
				total_q <= total_nxt;
				if (mem_we) begin
					valid_q[idx_q] <= 1'b1;
				end
				if (req_fire) begin
					cur_q <= (op == OP_TICK) ? start_idx : cur_eff;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q     <= op;
			idx_q    <= start_idx;
			demand_q <= (op == OP_ADD || op == OP_CONSUME) ? amount : '0;
		end else begin
			demand_q <= demand_nxt;
			if (state_q == ST_CONS) begin
				idx_q <= rd_addr;
			end
		end
		if (state_q == ST_FIN && rsp_free) begin
			rsp_unmet_q <= demand_q;
			rsp_total_q <= TOTAL_W'(total_q);
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/ecr_checker.sv
// Port-level checker of the expiring credit ring and its bind.
`default_nettype none

module ecr_checker
	import ecr_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_valid,
	input wire logic                req_ready,
	input wire logic [1:0]          op,
	input wire logic [AMT_W-1:0]    amount,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire logic [AMT_W-1:0]    unmet_demand,
	input wire logic [TOTAL_W-1:0]  total_left,
	input wire logic                psel,
	input wire logic                penable,
	input wire logic                pwrite,
	input wire logic [ADDR_W-1:0]   paddr,
	input wire logic [DATA_W-1:0]   pwdata,
	input wire logic [DATA_W-1:0]   prdata,
	input wire logic                pready
);

	// A waiting response word holds still.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(unmet_demand) && $stable(total_left))
		else $error("response word changed while stalled");

	// Demand goes unmet only when the store has run dry.
	a_unmet_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && unmet_demand != '0 |-> total_left == '0)
		else $error("unmet demand reported with credit left");

	// One request at a time: the block is busy right after taking one.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// The slot count never reads as zero.
	a_use_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && paddr[2] == REG_SLOTS_IN_USE |-> prdata != '0)
		else $error("slots_in_use reads as zero");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind expiring_credit_ring ecr_checker u_ecr_checker (.*);

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the expiring credit ring: stimulus, predictor and scoreboard.

module testbench;
	import ecr_pkg::*;

	localparam int SLOT_COUNT = 8;

	// The op field can also carry a code the block does not know; it must leave the store alone.
	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	// The register index sits in paddr[2]; index one holds no register, so a write there is dropped.
	localparam logic REG_UNUSED = 1'b1;

	// Worst correct run: about 700 words, each waiting on the block, a sender gap and a receiver
	// stall at the heaviest idling, plus the long receiver hold-off and the drain pauses. This
	// limit leaves ample margin over such a run.
	localparam int CYCLE_LIMIT = 500000;

	// Longest time the block may still be busy once the last response word is out.
	localparam int SETTLE_CYCLES = 16;

	// Length of the receiver hold-off that backs the block up into its request port.
	localparam int HOLD_CYCLES = 90;

	localparam int CHUNK_WORDS = 108;

	typedef struct packed {
		logic [AMT_W-1:0]   unmet;
		logic [TOTAL_W-1:0] total;
	} credit_result_t;

	// Scoreboard: it keeps its own copy of the ring and the slot count, works out the response
	// word for every accepted request and compares the block's response words in order.
	class credit_scoreboard;
		logic [AMT_W-1:0]   credit [SLOT_COUNT];
		int unsigned        cur;
		int unsigned        ring_len;
		logic [TOTAL_W-1:0] held;
		credit_result_t     expected [$];
		int                 errors;

		function new();
			ring_len = SLOT_COUNT;
			errors = 0;
			wipe();
		endfunction

		function void wipe();
			foreach (credit[i])
				credit[i] = '0;
			cur = 0;
			held = '0;
		endfunction

		// One place back around the active ring; an index outside the ring wraps to its top.
		function int unsigned back_one(int unsigned idx);
			if (idx == 0 || idx >= ring_len)
				return ring_len - 1;
			return idx - 1;
		endfunction

		// A write to the slot count is clamped into 1..SLOT_COUNT and empties the store.
		function void apply_setting(logic index, logic [DATA_W-1:0] value);
			int unsigned v;
			v = value[3:0];
			if (index != REG_SLOTS_IN_USE)
				return;
			if (v == 0)
				v = 1;
			if (v > SLOT_COUNT)
				v = SLOT_COUNT;
			ring_len = v;
			wipe();
		endfunction

		function void note_request(logic [1:0] code, logic [AMT_W-1:0] amt);
			int unsigned      c;
			int unsigned      walk;
			int unsigned      n;
			logic [AMT_W-1:0] room;
			logic [AMT_W-1:0] take;
			logic [AMT_W-1:0] demand;
			credit_result_t   res;
			c = (cur < ring_len) ? cur : 0;
			demand = '0;
			case (code)
				OP_ADD: begin
					// The slot saturates at all ones; the total only grows by what fit.
					room = '1 - credit[c];
					take = (amt < room) ? amt : room;
					credit[c] += take;
					held += take;
				end
				OP_TICK: begin
					c = back_one(c);
					held -= credit[c];
					credit[c] = '0;
				end
				OP_CONSUME: begin
					// Oldest slot first, the current slot last.
					demand = amt;
					walk = c;
					for (n = 0; n < ring_len && held != 0 && demand != 0; n++) begin
						walk = back_one(walk);
						if (credit[walk] >= demand) begin
							credit[walk] -= demand;
							held -= demand;
							demand = '0;
						end else begin
							demand -= credit[walk];
							held -= credit[walk];
							credit[walk] = '0;
						end
					end
				end
				default: ;
			endcase
			cur = c;
			res.unmet = demand;
			res.total = held;
			expected.push_back(res);
		endfunction

		function void check_response(logic [AMT_W-1:0] unmet, logic [TOTAL_W-1:0] total);
			credit_result_t want;
			if (expected.size() == 0) begin
				errors++;
				$display("%0t: response word with none expected (unmet %0d, total %0d)",
					$time, unmet, total);
				return;
			end
			want = expected.pop_front();
			if (unmet !== want.unmet) begin
				errors++;
				$display("%0t: unmet_demand expected %0d actual %0d", $time, want.unmet, unmet);
			end
			if (total !== want.total) begin
				errors++;
				$display("%0t: total_left expected %0d actual %0d", $time, want.total, total);
			end
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	logic [1:0]          op = OP_ADD;
	logic [AMT_W-1:0]    amount = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	logic [AMT_W-1:0]    unmet_demand;
	logic [TOTAL_W-1:0]  total_left;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	credit_scoreboard book = new();

	// Idling percentages of both sides; the stimulus process changes them between phases.
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	// The stimulus flips this token to ask the receiver for a long hold-off.
	bit          stall_token = 1'b0;
	bit          stall_seen = 1'b0;
	int unsigned hold_left = 0;

	int unsigned cycle_count = 0;

	expiring_credit_ring #(
		.SLOTS(SLOT_COUNT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.op(op),
		.amount(amount),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.unmet_demand(unmet_demand),
		.total_left(total_left),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// Receiver side. The hold-off is counted here, in this process, so the stimulus can keep
	// offering words while the block backs up. Otherwise ready drops at the current idle rate.
	always @(negedge clk) begin
		if (stall_token != stall_seen) begin
			stall_seen = stall_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Every response word accepted at a rising edge goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			book.check_response(unmet_demand, total_left);
	end

	// Offer one request word after a random gap and wait until the block takes it. Valid is only
	// lowered when a gap follows, so it never falls and rises within one time step.
	task automatic send_word(logic [1:0] code, logic [AMT_W-1:0] amt);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		@(negedge clk);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		op <= code;
		amount <= amt;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		book.note_request(code, amt);
	endtask

	// Stop offering words, wait for every expected response word, then let the block settle.
	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (book.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: a setup cycle, then the access cycle; the register takes the value at the edge
	// where the access phase meets pready.
	task automatic write_register(logic index, logic [DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		book.apply_setting(index, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Amounts mostly stay small so consumes meet stored credit, with full-range and near-full
	// values mixed in to reach saturation and totals above 32 bits.
	function automatic logic [AMT_W-1:0] draw_amount();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 45)
			return $urandom_range(300);
		else if (pick < 70)
			return $urandom;
		else if (pick < 85)
			return 32'hFFFF_FFFF - $urandom_range(255);
		else if (pick < 93)
			return '1;
		return '0;
	endfunction

	function automatic logic [1:0] draw_op();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 40)
			return OP_ADD;
		else if (pick < 65)
			return OP_TICK;
		else if (pick < 95)
			return OP_CONSUME;
		return OP_UNKNOWN;
	endfunction

	// A run of random words. With back_up set, the receiver holds off for a long stretch while
	// the sender offers words with no gaps, and later the sender pauses until all have come back.
	task automatic run_random(int unsigned words, bit back_up);
		int unsigned saved_pct;
		saved_pct = send_idle_pct;
		for (int unsigned n = 0; n < words; n++) begin
			if (back_up && n == 30) begin
				send_idle_pct = 0;
				stall_token <= ~stall_token;
			end
			if (back_up && n == 42)
				send_idle_pct = saved_pct;
			if (back_up && n == 60) begin
				@(negedge clk);
				req_valid <= 1'b0;
				while (book.pending() != 0)
					@(posedge clk);
			end
			send_word(draw_op(), draw_amount());
		end
	endtask

	initial begin
		logic [DATA_W-1:0] setting [6];

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset slot count of eight. A consume on the empty store reports
		// its whole demand unmet; then a slot is filled to all ones and overfilled to check
		// saturation, and an unknown op must leave everything as it was.
		send_word(OP_CONSUME, 32'd5);
		send_word(OP_ADD, 32'hFFFF_FFFF);
		send_word(OP_ADD, 32'd1);
		send_word(OP_UNKNOWN, 32'hAAAA_AAAA);
		// Fill two more slots so the total passes 32 bits.
		send_word(OP_TICK, 32'h5555_5555);
		send_word(OP_ADD, 32'hFFFF_FFFF);
		send_word(OP_TICK, 32'h0);
		send_word(OP_ADD, 32'h5555_5555);
		send_word(OP_ADD, 32'h0);
		// A zero demand takes nothing.
		send_word(OP_CONSUME, 32'h0);
		send_word(OP_TICK, 32'hFFFF_FFFF);
		send_word(OP_ADD, 32'd300);
		// Large demands drain the oldest slots first and finally run the store dry.
		send_word(OP_CONSUME, 32'hFFFF_FFFF);
		send_word(OP_CONSUME, 32'hFFFF_FFFF);
		send_word(OP_CONSUME, 32'hFFFF_FFFF);
		send_word(OP_ADD, 32'd40);

		// A write to the empty register index must neither change the slot count nor clear the
		// credit, so the consume after it still finds the forty.
		wait_drained();
		write_register(REG_UNUSED, 32'd2);
		send_word(OP_CONSUME, 32'd10);
		// A full turn of ticks expires all remaining credit.
		for (int i = 0; i < SLOT_COUNT; i++)
			send_word(OP_TICK, $urandom);
		send_word(OP_CONSUME, 32'd1);

		// Slot counts for the random part: the extremes, one in between, then writes of zero (taken
		// as one), fifteen (clamped to eight) and a random count, with random upper bits to be ignored.
		setting[0] = 32'd1;
		setting[1] = 32'd8;
		setting[2] = $urandom_range(2, 7);
		setting[3] = $urandom & 32'hFFFF_FFF0;
		setting[4] = $urandom | 32'h0000_000F;
		setting[5] = {28'($urandom_range(32'h0FFF_FFFF)), 4'(1 + $urandom_range(14))};

		for (int p = 0; p < 3; p++) begin
			for (int k = 0; k < 2; k++) begin
				wait_drained();
				case (p)
					0: begin
						send_idle_pct = 34;
						recv_idle_pct = 72;
					end
					1: begin
						send_idle_pct = 72;
						recv_idle_pct = 34;
					end
					default: begin
						send_idle_pct = 0;
						recv_idle_pct = 0;
					end
				endcase
				write_register(REG_SLOTS_IN_USE, setting[2 * p + k]);
				run_random(CHUNK_WORDS, (p == 0 && k == 0));
			end
		end

		wait_drained();
		if (book.errors == 0 && book.pending() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

>>> files.f
rtl/core/ecr_pkg.sv
rtl/core/expiring_credit_ring.sv
rtl/core/ecr_checker.sv
test/testbench.sv
